[rtl/fr90_pkg.sv]
// Shared types and codes for the 90-degree frame rotation engine.
// No dependencies; imported by fr90_seq and frame_rotate_cw90_unit.
package fr90_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic {
    STAT_OK        = 1'b0,
    STAT_NOT_READY = 1'b1
  } stat_t;

  typedef enum logic {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } reg_idx_t;

  localparam int unsigned SIDE_W  = 7;
  localparam int unsigned PIXEL_W = 24;

  // Response marker travelling from the sequencer to the output side.
  typedef struct packed {
    logic  valid;
    logic  last;
    stat_t status;
  } resp_t;

endpackage

[rtl/fr90_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module fr90_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/fr90_seq.sv]
// Load/fetch sequencer: frame fill count, rotated scan counters, store addressing.
// Depends on fr90_pkg.
module fr90_seq #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  fr90_pkg::cmd_t                     cmd,
  input  logic                               clear,
  input  logic [fr90_pkg::SIDE_W-1:0]        cols,
  input  logic [fr90_pkg::SIDE_W-1:0]        rows,
  output logic                               ram_en,
  output logic                               ram_we,
  output logic [$clog2(DEPTH)-1:0]           ram_addr,
  output fr90_pkg::resp_t                    resp
);
  import fr90_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (AW + 1 > 2 * SIDE_W) ? AW + 1 : 2 * SIDE_W;

  logic [LW-1:0]     load_count_r, load_count_nxt;
  logic [SIDE_W-1:0] out_row_r, out_row_nxt;
  logic [SIDE_W-1:0] out_col_r, out_col_nxt;
  logic              full_r, full_nxt;
  resp_t             resp_r, resp_nxt;

  logic [PW-1:0]     total;
  logic [PW-1:0]     count_ext;
  logic [SIDE_W-1:0] src_row;
  logic [PW-1:0]     rd_addr;
  logic              do_load;
  logic              do_fetch;
  logic              col_wrap;
  logic              row_wrap;

  assign total     = PW'(cols) * PW'(rows);
  assign count_ext = PW'(load_count_r);
  assign do_load   = accept && (cmd == CMD_LOAD) && !full_r && (count_ext < total);
  assign do_fetch  = accept && (cmd == CMD_FETCH) && full_r;

  // Output pixel (i,j) comes from input row rows-1-j, column i.
  assign src_row  = rows - SIDE_W'(1) - out_col_r;
  assign rd_addr  = PW'(src_row) * PW'(cols) + PW'(out_row_r);
  assign col_wrap = (out_col_r == rows - SIDE_W'(1));
  assign row_wrap = (out_row_r == cols - SIDE_W'(1));

  assign ram_en   = do_load || do_fetch;
  assign ram_we   = do_load;
  assign ram_addr = do_load ? load_count_r[AW-1:0] : rd_addr[AW-1:0];
  assign resp     = resp_r;

  always_comb begin
    load_count_nxt = load_count_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    full_nxt       = full_r;
    resp_nxt       = '{valid: accept && (cmd == CMD_FETCH), last: 1'b0,
                       status: full_r ? STAT_OK : STAT_NOT_READY};
    if (clear) begin
      load_count_nxt = '0;
      out_row_nxt    = '0;
      out_col_nxt    = '0;
      full_nxt       = 1'b0;
    end else if (do_load) begin
      load_count_nxt = load_count_r + LW'(1);
      if (count_ext + PW'(1) >= total) begin
        full_nxt = 1'b1;
      end
    end else if (do_fetch) begin
      if (col_wrap) begin
        out_col_nxt = '0;
        if (row_wrap) begin
          resp_nxt.last  = 1'b1;
          load_count_nxt = '0;
          out_row_nxt    = '0;
          full_nxt       = 1'b0;
        end else begin
          out_row_nxt = out_row_r + SIDE_W'(1);
        end
      end else begin
        out_col_nxt = out_col_r + SIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      full_r       <= 1'b0;
      resp_r       <= '{valid: 1'b0, last: 1'b0, status: STAT_OK};
    end else begin
      load_count_r <= load_count_nxt;
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
      full_r       <= full_nxt;
      resp_r       <= resp_nxt;
    end
  end

endmodule

[rtl/frame_rotate_cw90_unit.sv]
// Top level of the 90-degree clockwise frame rotation engine.
// Depends on fr90_pkg, fr90_ram and fr90_seq.

// Usage: set frame_cols and frame_rows over the APB port (0 is taken as 1,
// values above MAX_SIDE as MAX_SIDE; any write empties the frame), then issue
// load words in input raster order and fetch words to read the rotated image
// in its own raster order. The block takes one word per clock: every word is
// at most one access to the single-port frame store, and busy is high only in
// the first cycle after reset. A fetch returns its result in the cycle
// after it is accepted, on out_valid for that one cycle, because the store's
// read data is registered; the receiver cannot stall, so it must take every
// result as it comes. Loads beyond a full frame are dropped, a fetch before the
// frame is complete answers status 1 with a black pixel, and the fetch marked
// frame_last empties the block for the next frame. The store is not cleared
// after reset, so there is no startup pass.
module frame_rotate_cw90_unit #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  // Result channel.
  output logic        out_valid,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_last,
  output logic        out_status,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fr90_pkg::*;

  localparam int unsigned DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CLAMP_INT = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
  localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(CLAMP_INT);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

  logic [SIDE_W-1:0] cols_r, cols_nxt;
  logic [SIDE_W-1:0] rows_r, rows_nxt;
  logic              run_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic [SIDE_W-1:0] cols_eff;
  logic [SIDE_W-1:0] rows_eff;
  logic [SIDE_W-1:0] rd_reg;
  logic              accept;
  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;
  resp_t             resp;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (v > SIDE_LIMIT) begin
      return SIDE_LIMIT;
    end
    return v;
  endfunction

  // The register index is bit 2 of the byte address; lower bits are ignored.
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    rd_reg   = cols_r;
    unique case (cfg_idx)
      REG_FRAME_COLS: begin
        rd_reg = cols_r;
        if (cfg_wr) cols_nxt = pwdata[SIDE_W-1:0];
      end
      REG_FRAME_ROWS: begin
        rd_reg = rows_r;
        if (cfg_wr) rows_nxt = pwdata[SIDE_W-1:0];
      end
      default: rd_reg = cols_r;
    endcase
  end

  assign prdata = {{(32 - SIDE_W){1'b0}}, rd_reg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIDE_RESET;
      rows_r <= SIDE_RESET;
      run_r  <= 1'b0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      run_r  <= 1'b1;
    end
  end

  assign cols_eff  = clamp_side(cols_r);
  assign rows_eff  = clamp_side(rows_r);
  assign busy      = !run_r;
  assign accept    = start && !busy;
  assign ram_wdata = {in_red_in, in_green_in, in_blue_in};

  fr90_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cmd      (cmd_t'(in_command)),
    .clear    (cfg_wr),
    .cols     (cols_eff),
    .rows     (rows_eff),
    .ram_en   (ram_en),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .resp     (resp)
  );

  fr90_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // A not-ready answer carries a black pixel instead of stale read data.
  assign out_valid      = resp.valid;
  assign out_frame_last = resp.last;
  assign out_status     = resp.status;
  assign out_red_out    = (resp.status == STAT_OK) ? ram_rdata[23:16] : 8'd0;
  assign out_green_out  = (resp.status == STAT_OK) ? ram_rdata[15:8]  : 8'd0;
  assign out_blue_out   = (resp.status == STAT_OK) ? ram_rdata[7:0]   : 8'd0;

endmodule

[rtl/fr90_checker.sv]
// Port-level checks for the frame rotation engine, bound to its top level.
// Depends on frame_rotate_cw90_unit's port list only.
module fr90_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_command,
  input logic       out_valid,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic       out_frame_last,
  input logic       out_status
);

  // Every accepted fetch is answered in the following cycle.
  a_fetch_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command) |=> out_valid)
    else $error("fetch word not answered");

  // No result word without a fetch accepted in the previous cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_command))
    else $error("result word without fetch");

  // A not-ready answer is a black pixel and never ends a frame.
  a_not_ready_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0 &&
       !out_frame_last))
    else $error("not-ready answer carries pixel data");

  // After the last pixel the frame is empty, so a fetch right behind it is not ready.
  a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last && in_command && start && !busy) |=> out_status)
    else $error("frame not emptied after last pixel");

endmodule

bind frame_rotate_cw90_unit fr90_checker u_fr90_checker (.*);
